/* design/evpc_pkg.sv */
// ----------------------------------------------------------------------------
// evpc_pkg
// Shared widths, codes, payload types and clamp helpers for the eased
// viewport pan controller.
// ----------------------------------------------------------------------------
package evpc_pkg;

   localparam int COORD_BITS   = 16;
   localparam int FRAC_BITS    = 8;
   localparam int STEP_DIVISOR = 60;

   localparam int SPEED_W     = 9;
   localparam int SPEED_SHIFT = 8;
   localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1 << SPEED_SHIFT);

   // squared distance, radicand, root and long-division widths
   localparam int D2_W   = 2 * COORD_BITS + 1;
   localparam int RAD_W  = 2 * ((D2_W + 2 * FRAC_BITS + 1) / 2);
   localparam int SQ_W   = RAD_W / 2;
   localparam int NUM_W  = COORD_BITS + SQ_W + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   // reciprocal for the speed divide; the extra 8 shift bits cover a
   // divisor of up to 255 over a dividend of SQ_W bits
   localparam int DIV_SHIFT = SQ_W + 8;
   localparam int RECIP_W   = DIV_SHIFT + 1 - $clog2(STEP_DIVISOR);
   localparam logic [RECIP_W-1:0] STEP_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(STEP_DIVISOR - 1)) / 64'(STEP_DIVISOR));

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   // command codes
   localparam logic [2:0] CMD_MOVE        = 3'd0;
   localparam logic [2:0] CMD_MOVE_CENTER = 3'd1;
   localparam logic [2:0] CMD_PAN         = 3'd2;
   localparam logic [2:0] CMD_GOTO        = 3'd3;
   localparam logic [2:0] CMD_GOTO_CENTER = 3'd4;
   localparam logic [2:0] CMD_TICK        = 3'd5;
   localparam logic [2:0] CMD_RECLAMP     = 3'd6;

   // register indexes
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_VIEW_WIDTH   = 3'd0;
   localparam logic [2:0] REG_VIEW_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_BOUND_LEFT   = 3'd2;
   localparam logic [2:0] REG_BOUND_TOP    = 3'd3;
   localparam logic [2:0] REG_BOUND_WIDTH  = 3'd4;
   localparam logic [2:0] REG_BOUND_HEIGHT = 3'd5;
   localparam logic [2:0] REG_EASE_SPEED   = 3'd6;

   typedef struct packed {
      logic [2:0]            cmd;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] goal_x;
      logic [COORD_BITS-1:0] goal_y;
      logic                  at_goal;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] view_width;
      logic [COORD_BITS-1:0] view_height;
      logic [COORD_BITS-1:0] bound_left;
      logic [COORD_BITS-1:0] bound_top;
      logic [COORD_BITS-1:0] bound_width;
      logic [COORD_BITS-1:0] bound_height;
      logic [SPEED_W-1:0]    ease_speed;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic eval;
      logic sqrt_step;
      logic scale;
      logic load_div60;
      logic div_step;
      logic velocity;
      logic product;
      logic step_axes;
      logic commit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic long_tick;
      logic slot_free;
   } dp_sts_type;

   // keep a requested coordinate inside the allowed rectangle on one axis
   function automatic logic [COORD_BITS-1:0] clamp_axis(
      input logic [COORD_BITS:0]   n,
      input logic [COORD_BITS-1:0] left,
      input logic [COORD_BITS-1:0] span,
      input logic [COORD_BITS-1:0] view);
      logic [COORD_BITS+1:0] lim;
      logic [COORD_BITS+1:0] sum;
      logic [COORD_BITS+1:0] r;
      logic [COORD_BITS-1:0] res;
      lim = {2'b0, left} + {2'b0, span};
      sum = {1'b0, n} + {2'b0, view};
      if ({1'b0, n} < {2'b0, left}) begin
         r = {2'b0, left};
      end else if (sum > lim) begin
         r = (lim >= {2'b0, view}) ? (lim - {2'b0, view}) : '0;
      end else begin
         r = {1'b0, n};
      end
      res = (r > {2'b0, COORD_MAX}) ? COORD_MAX : r[COORD_BITS-1:0];
      return res;
   endfunction

   // centering offset, held at zero instead of wrapping
   function automatic logic [COORD_BITS:0] center_sub(
      input logic [COORD_BITS-1:0] c,
      input logic [COORD_BITS-1:0] view);
      logic [COORD_BITS-1:0] half;
      half = view >> 1;
      return (c > half) ? {1'b0, c - half} : '0;
   endfunction

endpackage

/* design/evpc_div.sv */
// ----------------------------------------------------------------------------
// evpc_div
// Restoring radix-2 divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module evpc_div (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [evpc_pkg::NUM_W-1:0]  num,
   input  logic [evpc_pkg::SQ_W-1:0]   den,
   output logic [evpc_pkg::NUM_W-1:0]  quo
);

   logic [evpc_pkg::SQ_W:0]    rem_ff;
   logic [evpc_pkg::SQ_W:0]    rem_in;
   logic [evpc_pkg::NUM_W-1:0] quo_ff;
   logic [evpc_pkg::NUM_W-1:0] quo_in;
   logic [evpc_pkg::SQ_W-1:0]  den_ff;
   logic [evpc_pkg::SQ_W:0]    trial;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial  = {rem_ff[evpc_pkg::SQ_W-1:0], quo_ff[evpc_pkg::NUM_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = '0;
         quo_in = num;
      end else if (step) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[evpc_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[evpc_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (load) begin
         den_ff <= den;
      end
   end

   assign quo = quo_ff;

endmodule

/* design/evpc_dp.sv */
// ----------------------------------------------------------------------------
// evpc_dp
// Datapath: position and target state, clamping, squared distance, shared
// root iteration, two divider lanes and the result register.
// ----------------------------------------------------------------------------
module evpc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  evpc_pkg::dp_cmd_type   cmd,
   output evpc_pkg::dp_sts_type   sts,
   input  evpc_pkg::cfg_type      cfg,
   input  evpc_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output evpc_pkg::rsp_type      rsp_data
);

   localparam int CB = evpc_pkg::COORD_BITS;
   localparam int SQ = evpc_pkg::SQ_W;
   localparam int NW = evpc_pkg::NUM_W;
   localparam int RW = evpc_pkg::RAD_W;

   logic [2:0]    op_ff;
   logic [CB-1:0] cx_ff, cy_ff;
   logic [CB-1:0] px_ff, py_ff, tx_ff, ty_ff;
   logic [CB-1:0] nx_ff, ny_ff, ntx_ff, nty_ff;
   logic [CB-1:0] nx_in, ny_in, ntx_in, nty_in;
   logic [2*CB-1:0] ax2_ff, ay2_ff;
   logic [RW-1:0] rad_ff, res_ff, bit_ff, root_sum;
   logic [SQ+evpc_pkg::SPEED_W-1:0] prod_ff;
   logic [SQ-1:0] spd_q_ff;
   logic [SQ-1:0] vel_ff;
   logic          rsp_valid_ff;
   evpc_pkg::rsp_type rsp_data_ff;

   logic [CB-1:0] ax, ay;
   logic          negx, negy, at_goal;
   logic [evpc_pkg::D2_W-1:0] d2;
   logic [SQ-1:0] root_d;
   logic [SQ+evpc_pkg::RECIP_W-1:0] recip_prod;
   logic [CB+SQ-1:0] mulx, muly;
   logic [NW-1:0] numx, numy, divx_q, divy_q;
   logic [CB:0]   qx, qy, sx, sy;

   // distance terms from the current state
   assign negx    = tx_ff < px_ff;
   assign negy    = ty_ff < py_ff;
   assign ax      = negx ? px_ff - tx_ff : tx_ff - px_ff;
   assign ay      = negy ? py_ff - ty_ff : ty_ff - py_ff;
   assign at_goal = (px_ff == tx_ff) && (py_ff == ty_ff);
   assign d2      = evpc_pkg::D2_W'(ax2_ff) + evpc_pkg::D2_W'(ay2_ff);
   assign root_d  = (res_ff[SQ-1:0] == '0) ? SQ'(1) : res_ff[SQ-1:0];

   assign sts.long_tick = (op_ff == evpc_pkg::CMD_TICK) && !at_goal &&
                          (d2 > evpc_pkg::D2_W'(1));
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   // next state for the commands that finish without iteration
   always_comb begin
      nx_in  = px_ff;
      ny_in  = py_ff;
      ntx_in = tx_ff;
      nty_in = ty_ff;
      case (op_ff)
         evpc_pkg::CMD_MOVE: begin
            nx_in = evpc_pkg::clamp_axis({1'b0, cx_ff}, cfg.bound_left,
                                         cfg.bound_width, cfg.view_width);
            ny_in = evpc_pkg::clamp_axis({1'b0, cy_ff}, cfg.bound_top,
                                         cfg.bound_height, cfg.view_height);
            ntx_in = nx_in;
            nty_in = ny_in;
         end
         evpc_pkg::CMD_MOVE_CENTER: begin
            nx_in = evpc_pkg::clamp_axis(evpc_pkg::center_sub(cx_ff, cfg.view_width),
                       cfg.bound_left, cfg.bound_width, cfg.view_width);
            ny_in = evpc_pkg::clamp_axis(evpc_pkg::center_sub(cy_ff, cfg.view_height),
                       cfg.bound_top, cfg.bound_height, cfg.view_height);
            ntx_in = nx_in;
            nty_in = ny_in;
         end
         evpc_pkg::CMD_PAN: begin
            nx_in = evpc_pkg::clamp_axis({1'b0, px_ff} + {1'b0, cx_ff}, cfg.bound_left,
                                         cfg.bound_width, cfg.view_width);
            ny_in = evpc_pkg::clamp_axis({1'b0, py_ff} + {1'b0, cy_ff}, cfg.bound_top,
                                         cfg.bound_height, cfg.view_height);
            ntx_in = nx_in;
            nty_in = ny_in;
         end
         evpc_pkg::CMD_GOTO: begin
            ntx_in = evpc_pkg::clamp_axis({1'b0, cx_ff}, cfg.bound_left,
                                          cfg.bound_width, cfg.view_width);
            nty_in = evpc_pkg::clamp_axis({1'b0, cy_ff}, cfg.bound_top,
                                          cfg.bound_height, cfg.view_height);
         end
         evpc_pkg::CMD_GOTO_CENTER: begin
            ntx_in = evpc_pkg::clamp_axis(evpc_pkg::center_sub(cx_ff, cfg.view_width),
                        cfg.bound_left, cfg.bound_width, cfg.view_width);
            nty_in = evpc_pkg::clamp_axis(evpc_pkg::center_sub(cy_ff, cfg.view_height),
                        cfg.bound_top, cfg.bound_height, cfg.view_height);
         end
         evpc_pkg::CMD_TICK: begin
            // snap when close; the long path overwrites these later
            if (!at_goal) begin
               nx_in = evpc_pkg::clamp_axis({1'b0, tx_ff}, cfg.bound_left,
                                            cfg.bound_width, cfg.view_width);
               ny_in = evpc_pkg::clamp_axis({1'b0, ty_ff}, cfg.bound_top,
                                            cfg.bound_height, cfg.view_height);
            end
         end
         evpc_pkg::CMD_RECLAMP: begin
            nx_in = evpc_pkg::clamp_axis({1'b0, px_ff}, cfg.bound_left,
                                         cfg.bound_width, cfg.view_width);
            ny_in = evpc_pkg::clamp_axis({1'b0, py_ff}, cfg.bound_top,
                                         cfg.bound_height, cfg.view_height);
            ntx_in = nx_in;
            nty_in = ny_in;
         end
         default: begin
         end
      endcase
   end

   // speed divide by reciprocal multiply
   assign recip_prod = prod_ff[evpc_pkg::SPEED_SHIFT +: SQ] * evpc_pkg::STEP_RECIP;

   // per-axis step numerators, rounded up on the negative side
   assign mulx = ax * vel_ff;
   assign muly = ay * vel_ff;
   assign numx = NW'(mulx) + (negx ? NW'(root_d - SQ'(1)) : '0);
   assign numy = NW'(muly) + (negy ? NW'(root_d - SQ'(1)) : '0);

   evpc_div u_div_x (
      .clock (clock),
      .load  (cmd.product),
      .step  (cmd.div_step),
      .num   (numx),
      .den   (root_d),
      .quo   (divx_q)
   );

   evpc_div u_div_y (
      .clock (clock),
      .load  (cmd.product),
      .step  (cmd.div_step),
      .num   (numy),
      .den   (root_d),
      .quo   (divy_q)
   );

   // move each axis by its quotient
   assign qx = divx_q[CB:0];
   assign qy = divy_q[CB:0];
   assign sx = negx ? (({1'b0, px_ff} > qx) ? {1'b0, px_ff} - qx : '0)
                    : {1'b0, px_ff} + qx;
   assign sy = negy ? (({1'b0, py_ff} > qy) ? {1'b0, py_ff} - qy : '0)
                    : {1'b0, py_ff} + qy;

   assign root_sum = res_ff + bit_ff;

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_data.cmd;
         cx_ff  <= req_data.coord_x;
         cy_ff  <= req_data.coord_y;
         ax2_ff <= ax * ax;
         ay2_ff <= ay * ay;
      end
      if (cmd.eval) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         ntx_ff <= ntx_in;
         nty_ff <= nty_in;
         rad_ff <= RW'({d2, {(2 * evpc_pkg::FRAC_BITS){1'b0}}});
         res_ff <= '0;
         bit_ff <= RW'(1) << (RW - 2);
      end
      if (cmd.sqrt_step) begin
         if (rad_ff >= root_sum) begin
            rad_ff <= rad_ff - root_sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.scale) begin
         prod_ff <= root_d * cfg.ease_speed;
      end
      if (cmd.load_div60) begin
         spd_q_ff <= SQ'(recip_prod >> evpc_pkg::DIV_SHIFT);
      end
      if (cmd.velocity) begin
         vel_ff <= (spd_q_ff < SQ'(1 << evpc_pkg::FRAC_BITS)) ?
                   SQ'(1 << evpc_pkg::FRAC_BITS) : spd_q_ff;
      end
      if (cmd.step_axes) begin
         nx_ff <= evpc_pkg::clamp_axis(sx, cfg.bound_left, cfg.bound_width,
                                       cfg.view_width);
         ny_ff <= evpc_pkg::clamp_axis(sy, cfg.bound_top, cfg.bound_height,
                                       cfg.view_height);
      end
      if (cmd.commit) begin
         rsp_data_ff.pos_x   <= nx_ff;
         rsp_data_ff.pos_y   <= ny_ff;
         rsp_data_ff.goal_x  <= ntx_ff;
         rsp_data_ff.goal_y  <= nty_ff;
         rsp_data_ff.at_goal <= (nx_ff == ntx_ff) && (ny_ff == nty_ff);
      end
   end

   // architectural state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff        <= '0;
         py_ff        <= '0;
         tx_ff        <= '0;
         ty_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         px_ff        <= nx_ff;
         py_ff        <= ny_ff;
         tx_ff        <= ntx_ff;
         ty_ff        <= nty_ff;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/evpc_ctrl.sv */
// ----------------------------------------------------------------------------
// evpc_ctrl
// Sequencer: walks one request through evaluate, root, speed divide,
// axis divides and commit; only a stepping tick runs the root and divides.
// ----------------------------------------------------------------------------
module evpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output evpc_pkg::dp_cmd_type cmd,
   input  evpc_pkg::dp_sts_type sts
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_EVAL  = 10'b00_0000_0010,
      S_SQRT  = 10'b00_0000_0100,
      S_SCALE = 10'b00_0000_1000,
      S_LD60  = 10'b00_0001_0000,
      S_VEL   = 10'b00_0010_0000,
      S_PROD  = 10'b00_0100_0000,
      S_DIV   = 10'b00_1000_0000,
      S_STEP  = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [evpc_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.long_tick) begin
               state_in = S_SQRT;
               cnt_in   = evpc_pkg::CNT_W'(evpc_pkg::SQ_W);
            end else begin
               state_in = S_OUT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == evpc_pkg::CNT_W'(1)) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_LD60;
         end
         S_LD60: begin
            cmd.load_div60 = 1'b1;
            state_in = S_VEL;
         end
         S_VEL: begin
            cmd.velocity = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.product = 1'b1;
            state_in = S_DIV;
            cnt_in   = evpc_pkg::CNT_W'(evpc_pkg::NUM_W);
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == evpc_pkg::CNT_W'(1)) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step_axes = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free
            cmd.commit = sts.slot_free;
            if (sts.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   sqrt_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT || state_ff == S_DIV) |-> cnt_ff != '0)
      else $error("iteration counter empty in an iterating state");

   commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.slot_free)
      else $error("commit while the result register is occupied");

   long_only_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && sts.long_tick) |=> state_ff == S_SQRT)
      else $error("long tick did not enter the root iteration");

endmodule

/* design/eased_viewport_pan_controller.sv */
// ----------------------------------------------------------------------------
// eased_viewport_pan_controller
// Viewport position and target kept inside a bounding rectangle, with an
// eased move of the position toward the target on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready with a command and two coordinates;
//   each request gives exactly one response on rsp_valid/rsp_ready carrying
//   position, target and an at-goal flag after the command.
//   Registers are to be written over the csr_ APB port while the block is
//   idle; this binds the user, as the block itself does not enforce it.
//   A tick that must step (distance above one pixel) first runs one root
//   iteration per bit of the distance, a reciprocal multiply for the speed
//   divide, then the two per-axis divides, one quotient bit per cycle;
//   every other command goes from evaluation straight to commit.
//   One request is in flight at a time; the next is taken once the previous
//   one has reached the response register, even while that response waits.
//   When the receiver stalls, a finished response is held and the following
//   request waits in its last cycle until the register frees.
//   Reset clears position and target to zero and loads the register defaults
//   (view 320x240, bounds 0,0,320,240, speed 64/256).
// ----------------------------------------------------------------------------
module eased_viewport_pan_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  evpc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output evpc_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [evpc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   evpc_pkg::cfg_type    cfg_ff;
   evpc_pkg::dp_cmd_type cmd;
   evpc_pkg::dp_sts_type sts;
   logic [2:0]           reg_idx;
   logic                 csr_wr;
   logic [evpc_pkg::SPEED_W-1:0] speed_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[evpc_pkg::CSR_AW-1:2];
   assign speed_wr   = (csr_pwdata[evpc_pkg::SPEED_W-1:0] > evpc_pkg::SPEED_ONE) ?
                       evpc_pkg::SPEED_ONE : csr_pwdata[evpc_pkg::SPEED_W-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width   <= 16'd320;
         cfg_ff.view_height  <= 16'd240;
         cfg_ff.bound_left   <= '0;
         cfg_ff.bound_top    <= '0;
         cfg_ff.bound_width  <= 16'd320;
         cfg_ff.bound_height <= 16'd240;
         cfg_ff.ease_speed   <= 9'd64;
      end else if (csr_wr) begin
         case (reg_idx)
            evpc_pkg::REG_VIEW_WIDTH:   cfg_ff.view_width   <= csr_pwdata[15:0];
            evpc_pkg::REG_VIEW_HEIGHT:  cfg_ff.view_height  <= csr_pwdata[15:0];
            evpc_pkg::REG_BOUND_LEFT:   cfg_ff.bound_left   <= csr_pwdata[15:0];
            evpc_pkg::REG_BOUND_TOP:    cfg_ff.bound_top    <= csr_pwdata[15:0];
            evpc_pkg::REG_BOUND_WIDTH:  cfg_ff.bound_width  <= csr_pwdata[15:0];
            evpc_pkg::REG_BOUND_HEIGHT: cfg_ff.bound_height <= csr_pwdata[15:0];
            evpc_pkg::REG_EASE_SPEED:   cfg_ff.ease_speed   <= speed_wr;
            default: begin
            end
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (reg_idx)
         evpc_pkg::REG_VIEW_WIDTH:   csr_prdata = 32'(cfg_ff.view_width);
         evpc_pkg::REG_VIEW_HEIGHT:  csr_prdata = 32'(cfg_ff.view_height);
         evpc_pkg::REG_BOUND_LEFT:   csr_prdata = 32'(cfg_ff.bound_left);
         evpc_pkg::REG_BOUND_TOP:    csr_prdata = 32'(cfg_ff.bound_top);
         evpc_pkg::REG_BOUND_WIDTH:  csr_prdata = 32'(cfg_ff.bound_width);
         evpc_pkg::REG_BOUND_HEIGHT: csr_prdata = 32'(cfg_ff.bound_height);
         evpc_pkg::REG_EASE_SPEED:   csr_prdata = 32'(cfg_ff.ease_speed);
         default:                    csr_prdata = '0;
      endcase
   end

   evpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   evpc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is in flight");

   goal_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.at_goal ==
         ((rsp_data.pos_x == rsp_data.goal_x) && (rsp_data.pos_y == rsp_data.goal_y)))
      else $error("at_goal disagrees with position and target");

   speed_capped: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.ease_speed <= evpc_pkg::SPEED_ONE)
      else $error("easing speed above one");

endmodule
